### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, quiet while rst is high.
`define CFAA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Boolean that must never hold at a clock edge.
`define CFAA_NEVER(label, expr, msg) \
  `CFAA_ASSERT(label, !(expr), msg)

`endif

### rtl/cfaa_pkg.sv
`timescale 1ns / 1ps

package cfaa_pkg;

  // Operation codes
  localparam logic OP_ACCEL   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Restoring divider depths (one quotient bit per stage)
  localparam int unsigned VOPT_STEPS = 31;
  localparam int unsigned DIV_STEPS  = 48;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_DESIRED_SPEED,
    REG_DESIRED_SPEED_FACTOR,
    REG_SPEED_LIMIT,
    REG_MIN_GAP,
    REG_TIME_HEADWAY,
    REG_RELAX_TIME,
    REG_SENSITIVITY,
    REG_TIME_STEP
  } cfaa_reg_t;

  // Per-item data carried alongside the dividers
  typedef struct packed {
    logic        op;
    logic        use_v0l;
    logic        use_zero;
    logic [30:0] v0l;
    logic [31:0] vs;
    logic [32:0] dv_mag;
    logic        dv_neg;
    logic [47:0] pos;
    logic [30:0] vc;
    logic [31:0] accel;
    logic        go;
    logic [46:0] adt16;
    logic [45:0] vdt;
    logic [61:0] vv;
    logic [61:0] mlo_dt;
    logic [46:0] mhi_dt;
    logic [33:0] x;
    logic [63:0] sprod;
    logic [48:0] t2;
    logic [45:0] half;
    logic        dsat;
  } cfaa_side_t;

  // One divider stage word: partial remainder, dividend bits still to use,
  // quotient so far, divisor, and the side data
  typedef struct packed {
    logic [32:0] rem;
    logic [47:0] dvd;
    logic [47:0] quo;
    logic [32:0] dvs;
    cfaa_side_t  side;
  } cfaa_div_t;

endpackage

### rtl/cfaa_div_step.sv
`timescale 1ns / 1ps

module cfaa_div_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cfaa_pkg::cfaa_div_t in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output cfaa_pkg::cfaa_div_t out_word
);
  import cfaa_pkg::*;

  logic [33:0] shifted;
  logic [34:0] diff;
  logic        take;
  cfaa_div_t   word_next;

  // Shift in one dividend bit and try to subtract the divisor
  always_comb begin
    shifted   = {in_word.rem, in_word.dvd[47]};
    diff      = {1'b0, shifted} - {2'b00, in_word.dvs};
    take      = ~diff[34];
    word_next = in_word;
    word_next.rem = take ? diff[32:0] : shifted[32:0];
    word_next.dvd = {in_word.dvd[46:0], 1'b0};
    word_next.quo = {in_word.quo[46:0], take};
  end

  assign in_ready = ~out_valid | out_ready;

  // Advance when the slot ahead frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

### rtl/car_following_accel_and_advance_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Car-following unit: opcode 0 returns a vehicle's acceleration from the full
// velocity difference model, opcode 1 advances lane position and speed by one
// time step. Every word gives exactly one result word. The unit is a fully
// pipelined datapath that takes one word per clock unless the output stalls,
// returning results in order: three front stages of products and compares, a
// 31-stage restoring divider for the optimal velocity, two setup stages, a
// 48-stage restoring divider shared by the relaxation term and the stopping
// distance, and the output register. Words keep flowing into empty slots while
// a result waits. The user must write registers through the cfg port only while
// the unit is empty; the unit does not enforce this. cfg_ready is always high.
module car_following_accel_and_advance_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         opcode,
  input  logic [47:0]  vehicle_position,
  input  logic [31:0]  vehicle_speed,
  input  logic         target_present,
  input  logic [47:0]  target_position,
  input  logic [31:0]  target_speed,
  input  logic [31:0]  accel_in,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [31:0]  accel_out,
  output logic [47:0]  new_position,
  output logic [30:0]  new_speed,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data
);
  import cfaa_pkg::*;

  typedef struct packed {
    logic        op;
    logic        present;
    logic [47:0] pos;
    logic [31:0] vs;
    logic [31:0] ts;
    logic [49:0] num;
    logic [61:0] dsprod;
    logic [30:0] vc;
    logic [31:0] accel;
    logic [62:0] adt;
  } a_t;

  typedef struct packed {
    logic        op;
    logic        use_v0l;
    logic        use_zero;
    logic [46:0] num;
    logic [30:0] v0l;
    logic [47:0] pos;
    logic [31:0] vs;
    logic [32:0] dv;
    logic [30:0] vc;
    logic [31:0] accel;
    logic        go;
    logic [46:0] adt16;
    logic [46:0] m;
    logic [45:0] vdt;
    logic [61:0] vv;
  } b_t;

  // Configuration registers
  logic [30:0] desired_speed, desired_speed_factor, speed_limit, min_gap;
  logic [30:0] time_headway, relax_time, sensitivity, time_step;
  logic [30:0] hw, rt;

  assign cfg_ready = 1'b1;
  assign hw = (time_headway == '0) ? 31'd1 : time_headway;
  assign rt = (relax_time == '0) ? 31'd1 : relax_time;

  // Decode register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      desired_speed        <= 31'd2162688;
      desired_speed_factor <= 31'd65536;
      speed_limit          <= 31'd2162688;
      min_gap              <= 31'd131072;
      time_headway         <= 31'd65536;
      relax_time           <= 31'd65536;
      sensitivity          <= 31'd32768;
      time_step            <= 31'd6554;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfaa_reg_t'(cfg_index))
        REG_DESIRED_SPEED:        desired_speed        <= cfg_data;
        REG_DESIRED_SPEED_FACTOR: desired_speed_factor <= cfg_data;
        REG_SPEED_LIMIT:          speed_limit          <= cfg_data;
        REG_MIN_GAP:              min_gap              <= cfg_data;
        REG_TIME_HEADWAY:         time_headway         <= cfg_data;
        REG_RELAX_TIME:           relax_time           <= cfg_data;
        REG_SENSITIVITY:          sensitivity          <= cfg_data;
        REG_TIME_STEP:            time_step            <= cfg_data;
        default:                  ;
      endcase
    end
  end

  // Stage enables, back to front
  logic        a_valid, b_valid, e_valid, o_en, a_en, b_en, c_en, e_en, f_en;
  logic        d1_valid [0:VOPT_STEPS];
  logic        d1_rdy   [0:VOPT_STEPS];
  cfaa_div_t   d1_word  [0:VOPT_STEPS];
  logic        sh_valid [0:DIV_STEPS];
  logic        sh_rdy   [0:DIV_STEPS];
  cfaa_div_t   sh_word  [0:DIV_STEPS];

  assign o_en = ~out_valid | out_ready;
  assign sh_rdy[DIV_STEPS] = o_en;
  assign f_en = ~sh_valid[0] | sh_rdy[0];
  assign e_en = ~e_valid | f_en;
  assign d1_rdy[VOPT_STEPS] = e_en;
  assign c_en = ~d1_valid[0] | d1_rdy[0];
  assign b_en = ~b_valid | c_en;
  assign a_en = ~a_valid | b_en;
  assign in_ready = a_en;

  // Stage A: gap, desired-speed product, a*dt
  a_t a, a_next;
  always_comb begin
    a_next.op      = opcode;
    a_next.present = target_present;
    a_next.pos     = vehicle_position;
    a_next.vs      = vehicle_speed;
    a_next.ts      = target_present ? target_speed : 32'd0;
    a_next.num     = {{2{target_position[47]}}, target_position}
                   - {{2{vehicle_position[47]}}, vehicle_position}
                   - {19'd0, min_gap};
    a_next.dsprod  = {31'd0, desired_speed} * {31'd0, desired_speed_factor};
    a_next.vc      = vehicle_speed[31] ? 31'd0 : vehicle_speed[30:0];
    a_next.accel   = accel_in;
    a_next.adt     = $signed({{31{accel_in[31]}}, accel_in})
                   * $signed({32'd0, time_step});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= in_valid;
    end
    if (a_en && in_valid) begin
      a <= a_next;
    end
  end

  // Stage B: classify gap, cap desired speed, truncate a*dt, v*dt and v*v
  b_t          b, b_next;
  logic        nonpos, big, d1sat;
  logic [62:0] negv;
  always_comb begin
    nonpos = a.num[49] | (a.num == '0);
    big    = ~a.num[49] & (a.num[48:47] != 2'b00);
    d1sat  = $signed(a.num) >= $signed({4'd0, hw, 15'd0});
    negv   = 63'd0 - {16'd0, a.vc, 16'd0};
    b_next.op       = a.op;
    b_next.use_zero = a.present & nonpos;
    b_next.use_v0l  = ~a.present | big | d1sat;
    b_next.num      = a.num[46:0];
    b_next.v0l      = (a.dsprod[61:16] > {15'd0, speed_limit}) ? speed_limit
                                                              : a.dsprod[46:16];
    b_next.pos      = a.pos;
    b_next.vs       = a.vs;
    b_next.dv       = {a.vs[31], a.vs} - {a.ts[31], a.ts};
    b_next.vc       = a.vc;
    b_next.accel    = a.accel;
    b_next.go       = $signed(a.adt) >= $signed(negv);
    b_next.adt16    = a.adt[62:16] + {46'd0, a.adt[62] & (a.adt[15:0] != '0)};
    b_next.m        = b_next.adt16[46] ? (47'd0 - b_next.adt16) : b_next.adt16;
    b_next.vdt      = 46'(({31'd0, a.vc} * {31'd0, time_step}) >> 16);
    b_next.vv       = {31'd0, a.vc} * {31'd0, a.vc};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_en) begin
      b_valid <= a_valid;
    end
    if (b_en && a_valid) begin
      b <= b_next;
    end
  end

  // Stage C: split |a*dt/65536| * dt, load the optimal-velocity divider
  cfaa_div_t c_next;
  always_comb begin
    c_next          = '0;
    c_next.rem      = {1'b0, b.num[46:15]};
    c_next.dvd      = {b.num[14:0], 33'd0};
    c_next.dvs      = {2'b00, hw};
    c_next.side.op       = b.op;
    c_next.side.use_v0l  = b.use_v0l;
    c_next.side.use_zero = b.use_zero;
    c_next.side.v0l      = b.v0l;
    c_next.side.vs       = b.vs;
    c_next.side.dv_neg   = b.dv[32];
    c_next.side.dv_mag   = b.dv[32] ? (33'd0 - b.dv) : b.dv;
    c_next.side.pos      = b.pos;
    c_next.side.vc       = b.vc;
    c_next.side.accel    = b.accel;
    c_next.side.go       = b.go;
    c_next.side.adt16    = b.adt16;
    c_next.side.vdt      = b.vdt;
    c_next.side.vv       = b.vv;
    c_next.side.mlo_dt   = {31'd0, b.m[30:0]} * {31'd0, time_step};
    c_next.side.mhi_dt   = {31'd0, b.m[46:31]} * {16'd0, time_step};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid[0] <= 1'b0;
    end else if (c_en) begin
      d1_valid[0] <= b_valid;
    end
    if (c_en && b_valid) begin
      d1_word[0] <= c_next;
    end
  end

  // Optimal-velocity divider: (gap - min_gap) * 65536 / time_headway
  for (genvar i = 0; i < VOPT_STEPS; i++) begin : g_vopt
    cfaa_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (d1_valid[i]),
      .in_ready  (d1_rdy[i]),
      .in_word   (d1_word[i]),
      .out_valid (d1_valid[i+1]),
      .out_ready (d1_rdy[i+1]),
      .out_word  (d1_word[i+1])
    );
  end

  // Stage E: pick vopt, speed error, sensitivity product
  cfaa_side_t  e_side, e_next;
  logic [30:0] q31, vopt;
  always_comb begin
    e_next = d1_word[VOPT_STEPS].side;
    q31    = d1_word[VOPT_STEPS].quo[30:0];
    if (e_next.use_zero) begin
      vopt = '0;
    end else if (e_next.use_v0l || (q31 >= e_next.v0l)) begin
      vopt = e_next.v0l;
    end else begin
      vopt = q31;
    end
    e_next.x     = {3'd0, vopt} - {{2{e_next.vs[31]}}, e_next.vs};
    e_next.sprod = {31'd0, e_next.dv_mag} * {33'd0, sensitivity};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_en) begin
      e_valid <= d1_valid[VOPT_STEPS];
    end
    if (e_en && d1_valid[VOPT_STEPS]) begin
      e_side <= e_next;
    end
  end

  // Stage F: sign terms, capped half product, load the shared divider
  cfaa_div_t   f_next;
  logic [33:0] xmag;
  logic [62:0] msum;
  logic        hsat;
  logic [32:0] na;
  logic [32:0] den;
  always_comb begin
    f_next      = '0;
    f_next.side = e_side;
    f_next.side.t2 = e_side.dv_neg ? (49'd0 - {1'b0, e_side.sprod[63:16]})
                                   : {1'b0, e_side.sprod[63:16]};
    msum = {1'b0, e_side.mhi_dt[30:0], 31'd0} + {1'b0, e_side.mlo_dt};
    hsat = (e_side.mhi_dt[46:31] != '0) | msum[62];
    f_next.side.half = hsat ? (46'd1 << 45) : {1'b0, msum[61:17]};
    xmag = e_side.x[33] ? (34'd0 - e_side.x) : e_side.x;
    na   = 33'd0 - {e_side.accel[31], e_side.accel};
    den  = {na[31:0], 1'b0};
    f_next.side.dsat = {19'd0, e_side.vv[61:48]} >= den;
    if (e_side.op == OP_ACCEL) begin
      f_next.rem = '0;
      f_next.dvd = {xmag[31:0], 16'd0};
      f_next.dvs = {2'b00, rt};
    end else begin
      f_next.rem = {19'd0, e_side.vv[61:48]};
      f_next.dvd = e_side.vv[47:0];
      f_next.dvs = den;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sh_valid[0] <= 1'b0;
    end else if (f_en) begin
      sh_valid[0] <= e_valid;
    end
    if (f_en && e_valid) begin
      sh_word[0] <= f_next;
    end
  end

  // Shared divider: |vopt - v| * 65536 / relax_time or v*v / (2|a|)
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    cfaa_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sh_valid[i]),
      .in_ready  (sh_rdy[i]),
      .in_word   (sh_word[i]),
      .out_valid (sh_valid[i+1]),
      .out_ready (sh_rdy[i+1]),
      .out_word  (sh_word[i+1])
    );
  end

  // Output stage: combine terms and saturate
  cfaa_side_t  gs;
  logic [47:0] quo;
  logic [49:0] t1, res, adv, hterm;
  logic [50:0] npos;
  logic [47:0] nv;
  logic [31:0] acc_next;
  logic [47:0] pos_next;
  logic [30:0] spd_next;
  logic        out_op;
  always_comb begin
    gs    = sh_word[DIV_STEPS].side;
    quo   = sh_word[DIV_STEPS].quo;
    t1    = gs.x[33] ? (50'd0 - {2'b00, quo}) : {2'b00, quo};
    res   = t1 - {gs.t2[48], gs.t2};
    hterm = gs.adt16[46] ? (50'd0 - {4'd0, gs.half}) : {4'd0, gs.half};
    if (gs.go) begin
      adv = {4'd0, gs.vdt} + hterm;
    end else if (gs.dsat) begin
      adv = 50'd1 << 48;
    end else begin
      adv = {2'b00, quo};
    end
    npos = {{3{gs.pos[47]}}, gs.pos} + {adv[49], adv};
    nv   = {17'd0, gs.vc} + {gs.adt16[46], gs.adt16};
    if (gs.op == OP_ACCEL) begin
      if ((res[49:31] == '0) || (res[49:31] == '1)) begin
        acc_next = res[31:0];
      end else begin
        acc_next = res[49] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
      pos_next = '0;
      spd_next = '0;
    end else begin
      if ((npos[50:47] == '0) || (npos[50:47] == '1)) begin
        pos_next = npos[47:0];
      end else begin
        pos_next = npos[50] ? 48'h8000_0000_0000 : 48'h7fff_ffff_ffff;
      end
      if (nv[47]) begin
        spd_next = '0;
        acc_next = '0;
      end else begin
        spd_next = (nv[46:31] != '0) ? 31'h7fff_ffff : nv[30:0];
        acc_next = gs.accel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_en) begin
      out_valid <= sh_valid[DIV_STEPS];
    end
    if (o_en && sh_valid[DIV_STEPS]) begin
      accel_out    <= acc_next;
      new_position <= pos_next;
      new_speed    <= spd_next;
      out_op       <= gs.op;
    end
  end

  // Checks
  `CFAA_NEVER(a_vopt_rem, d1_valid[VOPT_STEPS] && (d1_word[VOPT_STEPS].side.op == OP_ACCEL) && !d1_word[VOPT_STEPS].side.use_v0l && !d1_word[VOPT_STEPS].side.use_zero && (d1_word[VOPT_STEPS].rem >= d1_word[VOPT_STEPS].dvs), "vopt divider remainder not below divisor")
  `CFAA_NEVER(a_div_rem, sh_valid[DIV_STEPS] && ((sh_word[DIV_STEPS].side.op == OP_ACCEL) || (!sh_word[DIV_STEPS].side.go && !sh_word[DIV_STEPS].side.dsat)) && (sh_word[DIV_STEPS].rem >= sh_word[DIV_STEPS].dvs), "shared divider remainder not below divisor")
  `CFAA_ASSERT(a_accel_zero, out_valid && (out_op == OP_ACCEL) |-> (new_position == '0) && (new_speed == '0), "accel result carries position or speed")

endmodule
